>>> src/expiring_kv_cache_fifo_lru_unit_defines.svh
// Assertion macros for the expiring key-value cache checker.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef EXPIRING_KV_CACHE_FIFO_LRU_UNIT_DEFINES_SVH
`define EXPIRING_KV_CACHE_FIFO_LRU_UNIT_DEFINES_SVH

// same-cycle implication
`define EKV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EKV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ekv_pkg.sv
// Shared codes and control structs for the expiring key-value cache.
// No dependencies.
package ekv_pkg;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    localparam logic [2:0] ST_MISS     = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_UPDATED  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

    typedef struct packed {
        logic scan_start;
        logic rd_en;
        logic wr_en;
        logic set_valid;
        logic clr_valid;
    } store_ctl_t;

    typedef struct packed {
        logic start;
        logic unlink;
        logic append;
    } link_cmd_t;

endpackage

>>> src/ekv_if.sv
// Handshake channels of the expiring key-value cache.
// Depends on nothing; entry_total width follows CNT_W.
interface ekv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] item_key;
    logic [31:0] item_value;
    logic [31:0] expire_time;
    logic [31:0] current_time;
    modport source (output valid, operation, item_key, item_value, expire_time,
                    current_time, input ready);
    modport sink (input valid, operation, item_key, item_value, expire_time,
                  current_time, output ready);
endinterface

interface ekv_out_if #(parameter int CNT_W = 7);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [31:0]      read_value;
    logic [31:0]      hit_total;
    logic [31:0]      access_total;
    logic [CNT_W-1:0] entry_total;
    modport source (output valid, status, read_value, hit_total, access_total,
                    entry_total, input ready);
    modport sink (input valid, status, read_value, hit_total, access_total,
                  entry_total, output ready);
endinterface

interface ekv_cfg_if;
    logic valid;
    logic ready;
    logic evict_mode;
    modport source (output valid, evict_mode, input ready);
    modport sink (input valid, evict_mode, output ready);
endinterface

>>> src/ekv_store.sv
// Slot store: key, value and expiry memories, valid bits and the key scan.
// Depends on ekv_pkg.
module ekv_store #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ekv_pkg::store_ctl_t   ctl,
    input  logic [31:0]           scan_key,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [31:0]           wr_key,
    input  logic [VALUE_BITS-1:0] wr_value,
    input  logic [31:0]           wr_expiry,
    output ekv_pkg::scan_status_t scan_st,
    output logic [IDX_W-1:0]      hit_slot,
    output logic [IDX_W-1:0]      free_slot,
    output logic [VALUE_BITS-1:0] rd_value,
    output logic [31:0]           rd_expiry
);

    logic [31:0]           key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [31:0]           exp_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;
    logic               issue_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               cmp_reg;
    logic [31:0]        key_q_reg;
    logic               vbit_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic [31:0]        skey_reg;
    logic               done_reg;
    logic               found_reg;
    logic               free_hit_reg;
    logic [IDX_W-1:0]   hit_reg;
    logic [IDX_W-1:0]   free_reg;
    logic [VALUE_BITS-1:0] rdv_reg;
    logic [31:0]        rde_reg;

    logic match;
    logic last;
    logic finish;

    assign match  = cmp_reg && vbit_reg && (key_q_reg == skey_reg);
    assign last   = pidx_reg == IDX_W'(ENTRIES - 1);
    assign finish = cmp_reg && (match || last);

    // memory side: scan read, slot read, slot write
    always_ff @(posedge clk)
    begin
        key_q_reg <= key_mem[idx_reg];
        if (ctl.rd_en)
        begin
            rdv_reg <= val_mem[rd_addr];
            rde_reg <= exp_mem[rd_addr];
        end
        if (ctl.wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_value;
            exp_mem[wr_addr] <= wr_expiry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            issue_reg    <= 1'b0;
            idx_reg      <= '0;
            cmp_reg      <= 1'b0;
            vbit_reg     <= 1'b0;
            pidx_reg     <= '0;
            skey_reg     <= '0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            free_hit_reg <= 1'b0;
            hit_reg      <= '0;
            free_reg     <= '0;
        end
        else
        begin
            if (ctl.set_valid)
                valid_reg[wr_addr] <= 1'b1;
            if (ctl.clr_valid)
                valid_reg[wr_addr] <= 1'b0;

            if (ctl.scan_start)
            begin
                skey_reg     <= scan_key;
                issue_reg    <= 1'b1;
                idx_reg      <= '0;
                cmp_reg      <= 1'b0;
                done_reg     <= 1'b0;
                found_reg    <= 1'b0;
                free_hit_reg <= 1'b0;
            end
            else
            begin
                cmp_reg  <= issue_reg && !finish;
                vbit_reg <= valid_reg[idx_reg];
                pidx_reg <= idx_reg;
                if (issue_reg)
                begin
                    if (idx_reg == IDX_W'(ENTRIES - 1) || finish)
                        issue_reg <= 1'b0;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                if (cmp_reg)
                begin
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= pidx_reg;
                    end
                    // lowest free slot is the first invalid one seen
                    if (!vbit_reg && !free_hit_reg)
                    begin
                        free_hit_reg <= 1'b1;
                        free_reg     <= pidx_reg;
                    end
                end
                if (finish)
                    done_reg <= 1'b1;
            end
        end
    end

    assign scan_st.done  = done_reg;
    assign scan_st.found = found_reg;
    assign hit_slot      = hit_reg;
    assign free_slot     = free_reg;
    assign rd_value      = rdv_reg;
    assign rd_expiry     = rde_reg;

endmodule

>>> src/ekv_links.sv
// Order list: next/prev link memories with oldest, newest and entry count.
// Depends on ekv_pkg.
module ekv_links #(
    parameter int ENTRIES = 64,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ekv_pkg::link_cmd_t  cmd,
    input  logic [IDX_W-1:0]    slot,
    output logic [IDX_W-1:0]    oldest,
    output logic [CNT_W-1:0]    count,
    output logic                done
);

    typedef enum logic [3:0] {
        L_IDLE   = 4'b0001,
        L_READ   = 4'b0010,
        L_UNLINK = 4'b0100,
        L_APPEND = 4'b1000
    } lstate_t;

    logic [IDX_W-1:0] next_mem [ENTRIES];
    logic [IDX_W-1:0] prev_mem [ENTRIES];

    lstate_t          state_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             app_reg;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] nx_reg;
    logic [IDX_W-1:0] pv_reg;

    logic             nwe;
    logic [IDX_W-1:0] nwa;
    logic [IDX_W-1:0] nwd;
    logic             pwe;
    logic [IDX_W-1:0] pwa;
    logic [IDX_W-1:0] pwd;
    logic             multi;

    assign multi = count_reg > CNT_W'(1);

    always_comb
    begin
        nwe = 1'b0;
        nwa = pv_reg;
        nwd = nx_reg;
        pwe = 1'b0;
        pwa = nx_reg;
        pwd = pv_reg;
        if (state_reg == L_UNLINK && multi)
        begin
            nwe = slot_reg != head_reg;
            pwe = slot_reg != tail_reg;
        end
        else if (state_reg == L_APPEND && count_reg != '0)
        begin
            nwe = 1'b1;
            nwa = tail_reg;
            nwd = slot_reg;
            pwe = 1'b1;
            pwa = slot_reg;
            pwd = tail_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_READ)
        begin
            nx_reg <= next_mem[slot_reg];
            pv_reg <= prev_mem[slot_reg];
        end
        if (nwe)
            next_mem[nwa] <= nwd;
        if (pwe)
            prev_mem[pwa] <= pwd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            slot_reg  <= '0;
            app_reg   <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (cmd.start)
                    begin
                        slot_reg  <= slot;
                        app_reg   <= cmd.append;
                        state_reg <= cmd.unlink ? L_READ : L_APPEND;
                    end
                end
                L_READ:
                begin
                    state_reg <= L_UNLINK;
                end
                L_UNLINK:
                begin
                    if (!multi)
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                    end
                    else
                    begin
                        if (slot_reg == head_reg)
                            head_reg <= nx_reg;
                        if (slot_reg == tail_reg)
                            tail_reg <= pv_reg;
                    end
                    if (count_reg != '0)
                        count_reg <= count_reg - 1'b1;
                    state_reg <= app_reg ? L_APPEND : L_IDLE;
                end
                L_APPEND:
                begin
                    if (count_reg == '0)
                        head_reg <= slot_reg;
                    tail_reg  <= slot_reg;
                    count_reg <= count_reg + 1'b1;
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign oldest = head_reg;
    assign count  = count_reg;
    assign done   = (state_reg == L_UNLINK && !app_reg) || state_reg == L_APPEND;

endmodule

>>> src/expiring_kv_cache_fifo_lru_unit.sv
// Channel     | dir | payload
// cfg         | in  | evict_mode (0 FIFO, 1 LRU)
// request     | in  | operation, item_key, item_value, expire_time, current_time
// response    | out | status, read_value, hit_total, access_total, entry_total
//
// One request at a time. The key scan reads one slot per cycle from the key
// memory and stops early on a hit, then the order list is relinked if needed.
// A finished word sits in the response register; the next request is taken
// while it waits. No memory clearing after reset: valid bits gate all reads.
// Top level of the expiring key-value cache; depends on ekv_pkg, ekv_if,
// ekv_store and ekv_links.
module expiring_kv_cache_fifo_lru_unit #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ekv_cfg_if.sink     cfg,
    ekv_in_if.sink      request,
    ekv_out_if.source   response
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_RDSLOT = 6'b000100,
        S_DECIDE = 6'b001000,
        S_LINK   = 6'b010000,
        S_FIN    = 6'b100000
    } state_t;

    state_t                state_reg;
    logic                  mode_reg;
    logic [1:0]            op_reg;
    logic [31:0]           key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [31:0]           exp_reg;
    logic [31:0]           now_reg;
    logic [2:0]            status_reg;
    logic [31:0]           rv_reg;
    logic [31:0]           hit_cnt_reg;
    logic [31:0]           acc_cnt_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_status_reg;
    logic [31:0]           out_rv_reg;
    logic [31:0]           out_hit_reg;
    logic [31:0]           out_acc_reg;
    logic [CNT_W-1:0]      out_cnt_reg;

    ekv_pkg::store_ctl_t   sctl;
    ekv_pkg::scan_status_t scan_st;
    ekv_pkg::link_cmd_t    lcmd;
    logic [IDX_W-1:0]      hit_slot;
    logic [IDX_W-1:0]      free_slot;
    logic [IDX_W-1:0]      oldest;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      lslot;
    logic [VALUE_BITS-1:0] rd_value;
    logic [31:0]           rd_expiry;
    logic [CNT_W-1:0]      count;
    logic                  link_done;
    logic                  expired;
    logic                  full;
    logic                  accept;
    logic                  out_free;
    logic [2:0]            st_d;
    logic [31:0]           rv_d;
    logic                  hit_inc;
    logic                  acc_inc;
    logic                  d_unlink;
    logic                  d_append;
    logic                  d_wr;
    logic                  d_set;
    logic                  d_clr;

    assign cfg.ready     = 1'b1;
    assign request.ready = state_reg == S_IDLE;
    assign accept        = request.valid && request.ready;
    assign out_free      = !out_valid_reg || response.ready;

    assign expired = (rd_expiry != '0) && (rd_expiry < now_reg);
    assign full    = count == CNT_W'(ENTRIES);

    always_comb
    begin
        st_d     = ekv_pkg::ST_MISS;
        rv_d     = '0;
        hit_inc  = 1'b0;
        acc_inc  = 1'b0;
        d_unlink = 1'b0;
        d_append = 1'b0;
        d_wr     = 1'b0;
        d_set    = 1'b0;
        d_clr    = 1'b0;
        wr_addr  = hit_slot;
        unique case (op_reg)
            ekv_pkg::OP_GET:
            begin
                acc_inc = 1'b1;
                if (scan_st.found)
                begin
                    if (expired)
                    begin
                        d_unlink = 1'b1;
                        d_clr    = 1'b1;
                    end
                    else
                    begin
                        st_d     = ekv_pkg::ST_HIT;
                        rv_d     = 32'(rd_value);
                        hit_inc  = 1'b1;
                        d_unlink = mode_reg;
                        d_append = mode_reg;
                    end
                end
            end
            ekv_pkg::OP_PUT:
            begin
                if (scan_st.found)
                begin
                    st_d     = ekv_pkg::ST_UPDATED;
                    d_wr     = 1'b1;
                    d_unlink = 1'b1;
                    d_append = 1'b1;
                end
                else if (full)
                begin
                    // full: reuse the oldest slot only if it has expired
                    wr_addr = oldest;
                    if (expired)
                    begin
                        st_d     = ekv_pkg::ST_INSERTED;
                        d_wr     = 1'b1;
                        d_unlink = 1'b1;
                        d_append = 1'b1;
                    end
                    else
                    begin
                        st_d = ekv_pkg::ST_FULL;
                    end
                end
                else
                begin
                    wr_addr  = free_slot;
                    st_d     = ekv_pkg::ST_INSERTED;
                    d_wr     = 1'b1;
                    d_set    = 1'b1;
                    d_append = 1'b1;
                end
            end
            ekv_pkg::OP_ERASE:
            begin
                if (scan_st.found)
                begin
                    st_d     = ekv_pkg::ST_HIT;
                    d_unlink = 1'b1;
                    d_clr    = 1'b1;
                end
            end
            default:
            begin
                st_d = ekv_pkg::ST_MISS;
            end
        endcase
    end

    assign lslot           = wr_addr;
    assign sctl.scan_start = accept;
    assign sctl.rd_en      = state_reg == S_RDSLOT;
    assign sctl.wr_en      = (state_reg == S_DECIDE) && d_wr;
    assign sctl.set_valid  = (state_reg == S_DECIDE) && d_set;
    assign sctl.clr_valid  = (state_reg == S_DECIDE) && d_clr;
    assign lcmd.start      = (state_reg == S_DECIDE) && (d_unlink || d_append);
    assign lcmd.unlink     = d_unlink;
    assign lcmd.append     = d_append;

    ekv_store #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sctl),
        .scan_key  (request.item_key),
        .rd_addr   (scan_st.found ? hit_slot : oldest),
        .wr_addr   (wr_addr),
        .wr_key    (key_reg),
        .wr_value  (val_reg),
        .wr_expiry (exp_reg),
        .scan_st   (scan_st),
        .hit_slot  (hit_slot),
        .free_slot (free_slot),
        .rd_value  (rd_value),
        .rd_expiry (rd_expiry)
    );

    ekv_links #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_links (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (lcmd),
        .slot   (lslot),
        .oldest (oldest),
        .count  (count),
        .done   (link_done)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= request.operation;
            key_reg <= request.item_key;
            val_reg <= VALUE_BITS'(request.item_value);
            exp_reg <= request.expire_time;
            now_reg <= request.current_time;
        end
        if (state_reg == S_DECIDE)
        begin
            status_reg <= st_d;
            rv_reg     <= rv_d;
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_status_reg <= status_reg;
            out_rv_reg     <= rv_reg;
            out_hit_reg    <= hit_cnt_reg;
            out_acc_reg    <= acc_cnt_reg;
            out_cnt_reg    <= count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                mode_reg <= cfg.evict_mode;
            if (response.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_st.done)
                        state_reg <= S_RDSLOT;
                end
                S_RDSLOT:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    hit_cnt_reg <= hit_cnt_reg + 32'(hit_inc);
                    acc_cnt_reg <= acc_cnt_reg + 32'(acc_inc);
                    state_reg   <= lcmd.start ? S_LINK : S_FIN;
                end
                S_LINK:
                begin
                    if (link_done)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign response.valid        = out_valid_reg;
    assign response.status       = out_status_reg;
    assign response.read_value   = out_rv_reg;
    assign response.hit_total    = out_hit_reg;
    assign response.access_total = out_acc_reg;
    assign response.entry_total  = out_cnt_reg;

endmodule

>>> src/ekv_checker.sv
// Port-level checks for the expiring key-value cache, bound to the top level.
// Depends on ekv_pkg and the assertion macro header.
`include "expiring_kv_cache_fifo_lru_unit_defines.svh"

module ekv_checker #(
    parameter int ENTRIES = 64,
    parameter int CNT_W   = 7
) (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [2:0]       status,
    input logic [31:0]      read_value,
    input logic [CNT_W-1:0] entry_total
);

    `EKV_ASSERT_NOW(a_status_code, out_valid, status <= ekv_pkg::ST_FULL, "bad status code")
    `EKV_ASSERT_NOW(a_value_on_hit, out_valid && status != ekv_pkg::ST_HIT, read_value == '0, "read_value set without hit")
    `EKV_ASSERT_NOW(a_count_bound, out_valid, entry_total <= CNT_W'(ENTRIES), "entry count above capacity")
    `EKV_ASSERT_NXT(a_word_held, out_valid && !out_ready, out_valid && $stable(status), "response word dropped")

endmodule

bind expiring_kv_cache_fifo_lru_unit ekv_checker #(
    .ENTRIES (ENTRIES),
    .CNT_W   (CNT_W)
) u_ekv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (response.valid),
    .out_ready   (response.ready),
    .status      (response.status),
    .read_value  (response.read_value),
    .entry_total (response.entry_total)
);

>>> dv/ekv_tb_if.sv
`timescale 1ns / 1ps
// Testbench constants for the expiring key-value cache.
// No dependencies; the channel interfaces come from the RTL's ekv_if.sv.
package ekv_tb_pkg;
    localparam int SLOTS = 64;
endpackage

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the expiring key-value cache: random get/put/erase and unknown-op words on a
// small key pool, checked word by word against a slot-level cache predictor.
// Depends on ekv_pkg, ekv_if, ekv_tb_pkg and expiring_kv_cache_fifo_lru_unit.
module tb;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        logic [31:0] exp;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] rd;
        logic [31:0] hits;
        logic [31:0] gets;
        logic [6:0]  count;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    ekv_cfg_if cfg();
    ekv_in_if request();
    ekv_out_if #(.CNT_W(7)) response();

    expiring_kv_cache_fifo_lru_unit u_top (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .request(request), .response(response)
    );

    // cache predictor state
    logic [31:0] c_key [ekv_tb_pkg::SLOTS];
    logic [31:0] c_val [ekv_tb_pkg::SLOTS];
    logic [31:0] c_exp [ekv_tb_pkg::SLOTS];
    logic        c_vld [ekv_tb_pkg::SLOTS];
    logic [5:0]  c_nxt [ekv_tb_pkg::SLOTS];
    logic [5:0]  c_prv [ekv_tb_pkg::SLOTS];
    logic [5:0]  c_old, c_new;
    int          c_cnt;
    logic [31:0] c_hits, c_gets;
    logic        c_lru;

    req_t pending_words[$];
    rsp_t expected_words[$];
    int   mismatches = 0;
    int   sent = 0, got = 0, fulls = 0;
    bit   hold_off = 0;
    bit   cfg_go = 0;
    logic cfg_mode;

    function automatic bit stale(int s, logic [31:0] now);
        return c_exp[s] != 0 && c_exp[s] < now;
    endfunction

    function automatic void unlink(int s);
        if (c_cnt <= 1)
        begin
            c_old = 0;
            c_new = 0;
        end
        else
        begin
            if (s == c_old) c_old = c_nxt[s];
            else c_nxt[c_prv[s]] = c_nxt[s];
            if (s == c_new) c_new = c_prv[s];
            else c_prv[c_nxt[s]] = c_prv[s];
        end
        if (c_cnt > 0) c_cnt--;
    endfunction

    function automatic void append(int s);
        if (c_cnt == 0) c_old = s;
        else
        begin
            c_nxt[c_new] = s;
            c_prv[s] = c_new;
        end
        c_nxt[s] = 0;
        c_new = s;
        c_cnt++;
    endfunction

    function automatic void drop(int s);
        unlink(s);
        c_vld[s] = 0;
    endfunction

    function automatic rsp_t cache_lookup(req_t r);
        rsp_t o;
        int s = -1;
        int f = -1;
        o = '0;
        for (int i = 0; i < ekv_tb_pkg::SLOTS; i++)
            if (s < 0 && c_vld[i] && c_key[i] == r.key) s = i;
        if (r.op == ekv_pkg::OP_GET)
        begin
            c_gets++;
            if (s >= 0)
            begin
                if (stale(s, r.now)) drop(s);
                else
                begin
                    o.status = ekv_pkg::ST_HIT;
                    o.rd = c_val[s];
                    c_hits++;
                    if (c_lru)
                    begin
                        unlink(s);
                        append(s);
                    end
                end
            end
        end
        else if (r.op == ekv_pkg::OP_PUT)
        begin
            if (s >= 0)
            begin
                c_val[s] = r.val;
                c_exp[s] = r.exp;
                unlink(s);
                append(s);
                o.status = ekv_pkg::ST_UPDATED;
            end
            else
            begin
                if (c_cnt >= ekv_tb_pkg::SLOTS && stale(c_old, r.now)) drop(c_old);
                if (c_cnt < ekv_tb_pkg::SLOTS)
                    for (int i = ekv_tb_pkg::SLOTS - 1; i >= 0; i--)
                        if (!c_vld[i]) f = i;
                if (f >= 0)
                begin
                    c_vld[f] = 1;
                    c_key[f] = r.key;
                    c_val[f] = r.val;
                    c_exp[f] = r.exp;
                    append(f);
                    o.status = ekv_pkg::ST_INSERTED;
                end
                else o.status = ekv_pkg::ST_FULL;
            end
        end
        else if (r.op == ekv_pkg::OP_ERASE)
        begin
            if (s >= 0)
            begin
                drop(s);
                o.status = ekv_pkg::ST_HIT;
            end
        end
        o.hits = c_hits;
        o.gets = c_gets;
        o.count = c_cnt[6:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, seen, want);
        mismatches++;
    endtask

    // driver: bursts and gaps; the accepted word is popped before the next is chosen
    int burst_left = 0, gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                expected_words.push_back(cache_lookup(pending_words.pop_front()));
                sent++;
            end
            if (!(request.valid && !request.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    request.valid <= 1'b0;
                end
                else if (pending_words.size() > 0 && !cfg_go)
                begin
                    request.valid <= 1'b1;
                    {request.operation, request.item_key, request.item_value,
                     request.expire_time, request.current_time} <= pending_words[0];
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                else request.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge clk)
    begin
        rsp_t w, e;
        if (rst_n)
        begin
            if (response.valid && response.ready)
            begin
                w = {response.status, response.read_value, response.hit_total,
                     response.access_total, response.entry_total};
                got++;
                if (w.status == ekv_pkg::ST_FULL) fulls++;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", 0, 0);
                else
                begin
                    e = expected_words.pop_front();
                    if (w.status !== e.status) report_mismatch("status", w.status, e.status);
                    if (w.rd !== e.rd) report_mismatch("read_value", w.rd, e.rd);
                    if (w.hits !== e.hits) report_mismatch("hit_total", w.hits, e.hits);
                    if (w.gets !== e.gets) report_mismatch("access_total", w.gets, e.gets);
                    if (w.count !== e.count)
                        report_mismatch("entry_total", w.count, e.count);
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            response.ready <= !hold_off && (stall_phase < 12 || $urandom_range(0, 3) == 0);
        end
    end

    // watchdog: cycles with nothing accepted
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (response.valid && response.ready)
            || (cfg.valid && cfg.ready))
            quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // config port driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                c_lru = cfg.evict_mode;
                cfg.valid <= 1'b0;
                cfg_go <= 1'b0;
            end
            else if (cfg_go)
            begin
                cfg.valid <= 1'b1;
                cfg.evict_mode <= cfg_mode;
            end
        end
    end

    function automatic req_t make_word(int pool, logic [31:0] now);
        req_t r;
        int k = $urandom_range(0, 9);
        r.op = (k < 4) ? ekv_pkg::OP_GET : (k < 8) ? ekv_pkg::OP_PUT :
               (k < 9) ? ekv_pkg::OP_ERASE : 2'd3;
        r.key = ($urandom_range(0, 30) == 0) ? $urandom : 32'h1000 + $urandom_range(0, pool);
        r.val = $urandom;
        k = $urandom_range(0, 5);
        r.exp = (k == 0) ? 32'd0 : (k == 1) ? $urandom : now + $urandom_range(0, 60) - 20;
        r.now = now;
        return r;
    endfunction

    task automatic drain();
        wait (pending_words.size() == 0 && !request.valid && expected_words.size() == 0);
        repeat (90) @(posedge clk);
    endtask

    task automatic set_mode(logic m);
        cfg_mode = m;
        cfg_go <= 1'b1;
        @(posedge clk);
        wait (cfg_go == 1'b0);
        @(posedge clk);
    endtask

    logic [31:0] now_t;
    initial
    begin
        request.valid = 0;
        request.operation = ekv_pkg::OP_GET;
        request.item_key = 0;
        request.item_value = 0;
        request.expire_time = 0;
        request.current_time = 0;
        response.ready = 0;
        cfg.valid = 0;
        cfg.evict_mode = 0;
        c_lru = 0;
        c_cnt = 0;
        c_old = 0;
        c_new = 0;
        c_hits = 0;
        c_gets = 0;
        for (int i = 0; i < ekv_tb_pkg::SLOTS; i++)
        begin
            c_vld[i] = 0;
            c_key[i] = 0; c_val[i] = 0; c_exp[i] = 0; c_nxt[i] = 0; c_prv[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, every op, expiry edges, unknown op
        pending_words.push_back({ekv_pkg::OP_GET, 32'h0, 32'h0, 32'h0, 32'h0});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'h0, 32'hffffffff, 32'h0, 32'h0});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'hffffffff, 32'h0, 32'hffffffff,
                                 32'hffffffff});
        pending_words.push_back({ekv_pkg::OP_GET, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'h5, 32'h55, 32'd100, 32'd50});
        pending_words.push_back({ekv_pkg::OP_GET, 32'h5, 32'h0, 32'h0, 32'd100});
        pending_words.push_back({ekv_pkg::OP_GET, 32'h5, 32'h0, 32'h0, 32'd101});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'h6, 32'h66, 32'd10, 32'd1});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'h6, 32'h67, 32'd20, 32'd200});
        pending_words.push_back({ekv_pkg::OP_ERASE, 32'h6, 32'h0, 32'h0, 32'd300});
        pending_words.push_back({ekv_pkg::OP_ERASE, 32'h6, 32'h0, 32'h0, 32'd300});
        pending_words.push_back({2'd3, 32'h0, 32'hffffffff, 32'h1, 32'h1});
        pending_words.push_back({ekv_pkg::OP_GET, 32'h0, 32'h0, 32'h0, 32'hffffffff});
        drain();
        // fill past capacity, LRU mode, with a long receiver hold-off
        set_mode(1'b1);
        for (int i = 0; i < 70; i++)
            pending_words.push_back({ekv_pkg::OP_PUT, 32'h2000 + i, $urandom,
                                     (i < 3) ? 32'd400 : 32'd0, 32'd300});
        pending_words.push_back({ekv_pkg::OP_GET, 32'h2005, 32'h0, 32'h0, 32'd300});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'h3000, 32'h1, 32'h0, 32'd500});
        pending_words.push_back({ekv_pkg::OP_PUT, 32'h3001, 32'h1, 32'h0, 32'd500});
        hold_off <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_off <= 1'b0;
        drain();
        for (int i = 0; i < 70; i++)
            pending_words.push_back({ekv_pkg::OP_ERASE, 32'h2000 + i, 32'h0, 32'h0, 32'd0});
        pending_words.push_back({ekv_pkg::OP_ERASE, 32'h3000, 32'h0, 32'h0, 32'd0});
        pending_words.push_back({ekv_pkg::OP_ERASE, 32'h3001, 32'h0, 32'h0, 32'd0});
        drain();
        // random phases, alternating eviction mode
        now_t = 32'd1000;
        for (int p = 0; p < 4; p++)
        begin
            set_mode(p[0]);
            for (int i = 0; i < 240; i++)
            begin
                now_t = now_t + $urandom_range(0, 3);
                pending_words.push_back(make_word((p == 3) ? 90 : 24, now_t));
            end
            drain();
        end
        $display("Sent %0d words, checked %0d, %0d full replies, FIFO and LRU modes.",
                 sent, got, fulls);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
